>>> hw/rtl/maze_dfs_explorer_assert.svh
// Assertion macros for the maze explorer.
// Taken in by the top level with a plain include; needs nothing else.
`ifndef MAZE_DFS_EXPLORER_ASSERT_SVH
`define MAZE_DFS_EXPLORER_ASSERT_SVH

// Property that must hold at every clock edge out of reset
`define MDE_ASSERT_ALWAYS(label, clk_i, rst_ni, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication
`define MDE_ASSERT_IMP(label, clk_i, rst_ni, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define MDE_ASSERT_NEXT(label, clk_i, rst_ni, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/mde_pkg.sv
// Shared types, codes and helpers of the maze explorer.
// No dependencies; used by mde_decide and maze_dfs_explorer.
package mde_pkg;

  // Request codes
  localparam logic [0:0] REQ_START = 1'b0;
  localparam logic [0:0] REQ_STEP  = 1'b1;

  // Absolute directions, also the heading codes
  localparam logic [1:0] DIR_N = 2'd0;
  localparam logic [1:0] DIR_E = 2'd1;
  localparam logic [1:0] DIR_S = 2'd2;
  localparam logic [1:0] DIR_W = 2'd3;

  // Configuration register indexes
  localparam int CFG_AW = 2;
  localparam logic [CFG_AW-1:0] CFG_WALL_THRESHOLD = 2'd0;
  localparam logic [CFG_AW-1:0] CFG_GOAL_X         = 2'd1;
  localparam logic [CFG_AW-1:0] CFG_GOAL_Y         = 2'd2;
  localparam int CFG_DW = 12;

  // Register reset values
  localparam logic [11:0] THRESHOLD_RST = 12'd1000;
  localparam logic [3:0]  GOAL_RST      = 4'd7;

  typedef enum logic [2:0] {
    ST_IGNORED   = 3'd0,
    ST_ADVANCE   = 3'd1,
    ST_BACKTRACK = 3'd2,
    ST_GOAL      = 3'd3,
    ST_EXHAUSTED = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    MODE_IDLE    = 4'b0001,
    MODE_EXPLORE = 4'b0010,
    MODE_GOAL    = 4'b0100,
    MODE_DONE    = 4'b1000
  } mode_t;

  typedef struct packed {
    logic [0:0]  req_type;
    logic [11:0] left_level;
    logic [11:0] front_level;
    logic [11:0] right_level;
  } in_item_t;

  typedef struct packed {
    logic [2:0] status;
    logic [3:0] target_x;
    logic [3:0] target_y;
    logic [1:0] heading;
  } out_item_t;

  // Decision of one transaction, handed from the decide logic to the state and memories
  typedef struct packed {
    status_t    status;
    logic [1:0] heading;
    mode_t      mode;
    logic       mark_visited;
    logic       put_walls;
    logic       stack_we;
    logic       stack_start;
  } step_ctl_t;

  // Rotate sensor bits (bit0 front, bit1 right, bit3 left) into absolute directions
  function automatic logic [3:0] rot_dirs(input logic [3:0] rel, input logic [1:0] facing);
    logic [7:0] dbl;
    dbl = {rel, rel} << facing;
    return dbl[7:4];
  endfunction

endpackage

>>> hw/rtl/mde_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module mde_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // read data holds until the next read
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> hw/rtl/mde_decide.sv
// Decision logic of one transaction: goal test, neighbour choice, backtrack, new state.
// Uses mde_pkg; instantiated by maze_dfs_explorer.
module mde_decide #(
  parameter int GRID_SIDE = 16,
  localparam int CW = $clog2(GRID_SIDE),
  localparam int CELLS = GRID_SIDE * GRID_SIDE,
  localparam int CNTW = $clog2(CELLS + 1)
) (
  input  logic [0:0]        req_type,
  input  mde_pkg::mode_t    mode,
  input  logic [CW-1:0]     pos_x,
  input  logic [CW-1:0]     pos_y,
  input  logic [1:0]        facing,
  input  logic [CNTW-1:0]   count,
  input  logic [3:0]        walls,
  input  logic [3:0]        vis,
  input  logic [3:0]        nb_in,
  input  logic [CW-1:0]     nb_x [4],
  input  logic [CW-1:0]     nb_y [4],
  input  logic [CW-1:0]     top_x,
  input  logic [CW-1:0]     top_y,
  input  logic [3:0]        goal_x,
  input  logic [3:0]        goal_y,
  output mde_pkg::step_ctl_t ctl,
  output logic [CW-1:0]     new_x,
  output logic [CW-1:0]     new_y,
  output logic [CNTW-1:0]   next_count
);

  localparam int CMPW = ((CW > 4) ? CW : 4) + 1;

  logic [3:0]      open_dirs;
  logic            found;
  logic [1:0]      sel;
  logic            in_goal;
  logic [CMPW-1:0] px_c, py_c, gx_c, gy_c;
  logic [CW:0]     px, py, tx, ty;
  logic [1:0]      bt_head;

  // Goal block test, goal cells beyond the grid never match
  always_comb begin
    px_c = CMPW'(pos_x);
    py_c = CMPW'(pos_y);
    gx_c = CMPW'(goal_x);
    gy_c = CMPW'(goal_y);
    in_goal = ((px_c == gx_c) || (px_c == gx_c + CMPW'(1))) &&
              ((py_c == gy_c) || (py_c == gy_c + CMPW'(1)));
  end

  // First open, unvisited, in-grid neighbour in order N, E, S, W
  assign open_dirs = ~walls & nb_in & ~vis;
  assign found     = |open_dirs;

  always_comb begin
    if (open_dirs[0]) begin
      sel = mde_pkg::DIR_N;
    end else if (open_dirs[1]) begin
      sel = mde_pkg::DIR_E;
    end else if (open_dirs[2]) begin
      sel = mde_pkg::DIR_S;
    end else begin
      sel = mde_pkg::DIR_W;
    end
  end

  // Heading after a backtrack: face the travel direction if adjacent
  always_comb begin
    px = {1'b0, pos_x};
    py = {1'b0, pos_y};
    tx = {1'b0, top_x};
    ty = {1'b0, top_y};
    if (tx == px && ty == py + 1'b1) begin
      bt_head = mde_pkg::DIR_N;
    end else if (ty == py && tx == px + 1'b1) begin
      bt_head = mde_pkg::DIR_E;
    end else if (tx == px && ty + 1'b1 == py) begin
      bt_head = mde_pkg::DIR_S;
    end else if (ty == py && tx + 1'b1 == px) begin
      bt_head = mde_pkg::DIR_W;
    end else begin
      bt_head = facing;
    end
  end

  // Transaction outcome
  always_comb begin
    ctl.status       = mde_pkg::ST_IGNORED;
    ctl.heading      = facing;
    ctl.mode         = mode;
    ctl.mark_visited = 1'b0;
    ctl.put_walls    = 1'b0;
    ctl.stack_we     = 1'b0;
    ctl.stack_start  = 1'b0;
    new_x            = pos_x;
    new_y            = pos_y;
    next_count       = count;
    unique case (mode) inside
      mde_pkg::MODE_IDLE: begin
        if (req_type == mde_pkg::REQ_START) begin
          ctl.mark_visited = 1'b1;
          ctl.stack_we     = 1'b1;
          ctl.stack_start  = 1'b1;
          ctl.mode         = mde_pkg::MODE_EXPLORE;
          next_count       = CNTW'(1);
        end
      end
      mde_pkg::MODE_EXPLORE: begin
        if (req_type == mde_pkg::REQ_STEP) begin
          ctl.mark_visited = 1'b1;
          ctl.put_walls    = 1'b1;
          if (in_goal) begin
            ctl.mode   = mde_pkg::MODE_GOAL;
            ctl.status = mde_pkg::ST_GOAL;
          end else if (found) begin
            ctl.status  = mde_pkg::ST_ADVANCE;
            ctl.heading = sel;
            new_x       = nb_x[sel];
            new_y       = nb_y[sel];
            // full stack drops the push, the move still happens
            if (count < CNTW'(CELLS)) begin
              ctl.stack_we = 1'b1;
              next_count   = count + CNTW'(1);
            end
          end else if (count <= CNTW'(1)) begin
            ctl.mode   = mde_pkg::MODE_DONE;
            ctl.status = mde_pkg::ST_EXHAUSTED;
          end else begin
            ctl.status  = mde_pkg::ST_BACKTRACK;
            ctl.heading = bt_head;
            new_x       = top_x;
            new_y       = top_y;
            next_count  = count - CNTW'(1);
          end
        end
      end
      mde_pkg::MODE_GOAL, mde_pkg::MODE_DONE: ;
      default: ;
    endcase
  end

endmodule

>>> hw/rtl/maze_dfs_explorer.sv
// Depth-first maze explorer. A transaction passes two engine steps: a read step reads
// the wall, visited and trail memories around the current cell, then a decide step decides
// the move and writes back, stalled while the output register holds an untaken result. The
// next transaction's reads start only once the previous one's decide step has set the
// position; an input register and an output register let a new transaction be taken while
// a result waits. After reset a clearing pass zeroes the wall and visited memories, one
// cell a cycle, over all (2**ceil(log2 GRID_SIDE))**2 addresses (256 at the default size);
// no transaction is taken meanwhile, configuration writes are.
// Uses mde_pkg, mde_ram, mde_decide and maze_dfs_explorer_assert.svh.
`include "maze_dfs_explorer_assert.svh"

module maze_dfs_explorer #(
  parameter int GRID_SIDE = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  mde_pkg::in_item_t               in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output mde_pkg::out_item_t              out_data,
  input  logic                            cfg_we,
  input  logic [mde_pkg::CFG_AW-1:0]      cfg_addr,
  input  logic [mde_pkg::CFG_DW-1:0]      cfg_wdata
);

  localparam int CW     = $clog2(GRID_SIDE);
  localparam int MAW    = 2 * CW;
  localparam int MDEPTH = 1 << MAW;
  localparam int CELLS  = GRID_SIDE * GRID_SIDE;
  localparam int SAW    = $clog2(CELLS);
  localparam int CNTW   = $clog2(CELLS + 1);

  // Configuration
  logic [11:0] thr_r;
  logic [3:0]  goal_x_r, goal_y_r;

  // Input register, engine stage, output register
  logic               hold_valid_r;
  mde_pkg::in_item_t  hold_r;
  logic               e1_valid_r;
  logic [0:0]         e1_req_r;
  logic [3:0]         e1_sens_r;
  logic               out_valid_r;
  mde_pkg::out_item_t out_r;

  // Explorer state
  logic [CW-1:0]   pos_x_r, pos_y_r;
  logic [1:0]      facing_r;
  logic [CNTW-1:0] cnt_r;
  mde_pkg::mode_t  mode_r;

  // Clearing pass
  logic           clr_busy_r;
  logic [MAW-1:0] clr_addr_r;

  logic               in_fire, e0_fire, e1_fire, step_e0;
  logic [3:0]         rel, sens_abs;
  logic [CW-1:0]      nb_x [4];
  logic [CW-1:0]      nb_y [4];
  logic [MAW-1:0]     nb_addr [4];
  logic [3:0]         nb_in;
  logic [CW:0]        xp1, yp1;
  logic [MAW-1:0]     cur_addr;
  logic [3:0]         wall_rd, vis_rd;
  logic [MAW-1:0]     stack_rd;
  logic [CNTW-1:0]    cnt_m2;
  logic [SAW-1:0]     stack_waddr;
  mde_pkg::step_ctl_t ctl;
  logic [CW-1:0]      new_x, new_y;
  logic [CNTW-1:0]    next_count;

  // Handshakes
  assign e0_fire  = hold_valid_r && !e1_valid_r;
  assign e1_fire  = e1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !clr_busy_r && (!hold_valid_r || e0_fire);
  assign in_fire  = in_valid && in_ready;

  // Neighbour cells and grid bounds
  always_comb begin
    xp1 = {1'b0, pos_x_r} + 1'b1;
    yp1 = {1'b0, pos_y_r} + 1'b1;
    nb_x[0] = pos_x_r;            nb_y[0] = yp1[CW-1:0];
    nb_x[1] = xp1[CW-1:0];        nb_y[1] = pos_y_r;
    nb_x[2] = pos_x_r;            nb_y[2] = pos_y_r - CW'(1);
    nb_x[3] = pos_x_r - CW'(1);   nb_y[3] = pos_y_r;
    nb_in[0] = yp1 < (CW+1)'(GRID_SIDE);
    nb_in[1] = xp1 < (CW+1)'(GRID_SIDE);
    nb_in[2] = pos_y_r != '0;
    nb_in[3] = pos_x_r != '0;
    for (int d = 0; d < 4; d++) begin
      nb_addr[d] = {nb_y[d], nb_x[d]};
    end
  end

  assign cur_addr = {pos_y_r, pos_x_r};

  // Sensor thresholds, rotated by heading
  assign step_e0  = (hold_r.req_type == mde_pkg::REQ_STEP) && (mode_r == mde_pkg::MODE_EXPLORE);
  assign rel      = {hold_r.left_level > thr_r, 1'b0,
                     hold_r.right_level > thr_r, hold_r.front_level > thr_r};
  assign sens_abs = mde_pkg::rot_dirs(rel, facing_r);

  // Wall memories, one per direction; outside the clearing pass walls are only ever set
  for (genvar k = 0; k < 4; k++) begin : g_wall
    localparam int OPP = (k + 2) % 4;
    logic           we;
    logic [MAW-1:0] waddr;

    // own wall in the decide cycle, neighbour's mirrored wall in the read cycle
    assign we = clr_busy_r ||
                (e1_fire && ctl.put_walls && e1_sens_r[k]) ||
                (e0_fire && step_e0 && sens_abs[OPP] && nb_in[OPP]);
    assign waddr = clr_busy_r ? clr_addr_r : (e1_valid_r ? cur_addr : nb_addr[OPP]);

    mde_ram #(.WIDTH(1), .DEPTH(MDEPTH)) u_wall (
      .clk   (clk),
      .we    (we),
      .waddr (waddr),
      .wdata (!clr_busy_r),
      .re    (e0_fire),
      .raddr (cur_addr),
      .rdata (wall_rd[k])
    );
  end

  // Visited memory, one copy per neighbour so all four read at once
  for (genvar k = 0; k < 4; k++) begin : g_vis
    mde_ram #(.WIDTH(1), .DEPTH(MDEPTH)) u_vis (
      .clk   (clk),
      .we    (clr_busy_r || (e1_fire && ctl.mark_visited)),
      .waddr (clr_busy_r ? clr_addr_r : cur_addr),
      .wdata (!clr_busy_r),
      .re    (e0_fire),
      .raddr (nb_addr[k]),
      .rdata (vis_rd[k])
    );
  end

  // Trail stack: the entry below the top is read ahead for a backtrack
  assign cnt_m2      = cnt_r - CNTW'(2);
  assign stack_waddr = ctl.stack_start ? '0 : cnt_r[SAW-1:0];

  mde_ram #(.WIDTH(MAW), .DEPTH(CELLS)) u_trail (
    .clk   (clk),
    .we    (e1_fire && ctl.stack_we),
    .waddr (stack_waddr),
    .wdata ({new_y, new_x}),
    .re    (e0_fire),
    .raddr (cnt_m2[SAW-1:0]),
    .rdata (stack_rd)
  );

  mde_decide #(.GRID_SIDE(GRID_SIDE)) u_decide (
    .req_type   (e1_req_r),
    .mode       (mode_r),
    .pos_x      (pos_x_r),
    .pos_y      (pos_y_r),
    .facing     (facing_r),
    .count      (cnt_r),
    .walls      (wall_rd | e1_sens_r),
    .vis        (vis_rd),
    .nb_in      (nb_in),
    .nb_x       (nb_x),
    .nb_y       (nb_y),
    .top_x      (stack_rd[CW-1:0]),
    .top_y      (stack_rd[MAW-1:CW]),
    .goal_x     (goal_x_r),
    .goal_y     (goal_y_r),
    .ctl        (ctl),
    .new_x      (new_x),
    .new_y      (new_y),
    .next_count (next_count)
  );

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r    <= mde_pkg::THRESHOLD_RST;
      goal_x_r <= mde_pkg::GOAL_RST;
      goal_y_r <= mde_pkg::GOAL_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        mde_pkg::CFG_WALL_THRESHOLD: thr_r    <= cfg_wdata;
        mde_pkg::CFG_GOAL_X:         goal_x_r <= cfg_wdata[3:0];
        mde_pkg::CFG_GOAL_Y:         goal_y_r <= cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  // Clearing pass after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      clr_addr_r <= clr_addr_r + MAW'(1);
      if (&clr_addr_r) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  // Pipeline control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
      e1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (in_fire) begin
        hold_valid_r <= 1'b1;
      end else if (e0_fire) begin
        hold_valid_r <= 1'b0;
      end
      if (e0_fire) begin
        e1_valid_r <= 1'b1;
      end else if (e1_fire) begin
        e1_valid_r <= 1'b0;
      end
      if (e1_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      hold_r <= in_data;
    end
    if (e0_fire) begin
      e1_req_r  <= hold_r.req_type;
      e1_sens_r <= step_e0 ? sens_abs : 4'b0000;
    end
    if (e1_fire) begin
      out_r.status   <= ctl.status;
      out_r.target_x <= 4'(new_x);
      out_r.target_y <= 4'(new_y);
      out_r.heading  <= ctl.heading;
    end
  end

  // Explorer state update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_x_r  <= '0;
      pos_y_r  <= '0;
      facing_r <= mde_pkg::DIR_N;
      cnt_r    <= '0;
      mode_r   <= mde_pkg::MODE_IDLE;
    end else if (e1_fire) begin
      pos_x_r  <= new_x;
      pos_y_r  <= new_y;
      facing_r <= ctl.heading;
      cnt_r    <= next_count;
      mode_r   <= ctl.mode;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Checks
  `MDE_ASSERT_IMP(a_no_take_in_clear, clk, rst_n, clr_busy_r, !in_ready, "transaction taken during clearing pass")
  `MDE_ASSERT_IMP(a_trail_nonempty, clk, rst_n, mode_r == mde_pkg::MODE_EXPLORE, cnt_r != '0, "exploring with an empty trail")
  `MDE_ASSERT_NEXT(a_goal_sticks, clk, rst_n, mode_r == mde_pkg::MODE_GOAL, mode_r == mde_pkg::MODE_GOAL, "left goal mode without reset")
  `MDE_ASSERT_ALWAYS(a_pos_in_grid, clk, rst_n, ({1'b0, pos_x_r} < (CW+1)'(GRID_SIDE)) && ({1'b0, pos_y_r} < (CW+1)'(GRID_SIDE)), "position outside the grid")

endmodule

>>> tb/tb_top.sv
// Self-checking bench for maze_dfs_explorer: one depth-first exploration under several
// wall thresholds and goal placements, every move checked against a built-in explorer.
// Depends on mde_pkg and the maze_dfs_explorer RTL only.
`timescale 1ns / 100ps

module tb_top;

  localparam int GRID_SIDE   = 16;
  localparam int CELLS       = GRID_SIDE * GRID_SIDE;
  localparam int CYCLE_LIMIT = 100000;
  localparam int MOVE_TARGET = 420;

  // Explorer mirror plus the queue of moves still owed by the block
  class maze_scoreboard;
    logic [11:0]        threshold;
    int                 goal_x, goal_y;
    logic [3:0]         walls [CELLS];
    bit                 seen [CELLS];
    int                 trail [CELLS];
    int                 trail_len;
    int                 px, py;
    logic [1:0]         face;
    mde_pkg::mode_t     mode;
    mde_pkg::out_item_t moves_due [$];
    int                 errors;
    int                 live_results;

    function new();
      threshold = mde_pkg::THRESHOLD_RST;
      goal_x    = mde_pkg::GOAL_RST;
      goal_y    = mde_pkg::GOAL_RST;
      foreach (walls[i]) begin
        walls[i] = '0;
        seen[i]  = 1'b0;
        trail[i] = 0;
      end
      trail_len    = 0;
      px           = 0;
      py           = 0;
      face         = mde_pkg::DIR_N;
      mode         = mde_pkg::MODE_IDLE;
      errors       = 0;
      live_results = 0;
    endfunction

    function void set_regs(logic [11:0] thr, logic [3:0] gx, logic [3:0] gy);
      threshold = thr;
      goal_x    = gx;
      goal_y    = gy;
    endfunction

    function int pending();
      return moves_due.size();
    endfunction

    // Neighbour of the current cell in direction dir; 0 when it is off the grid
    function bit step_to(int dir, output int x, output int y);
      x = px;
      y = py;
      case (dir)
        mde_pkg::DIR_N: y = py + 1;
        mde_pkg::DIR_E: x = px + 1;
        mde_pkg::DIR_S: y = py - 1;
        default: x = px - 1;
      endcase
      return x >= 0 && x < GRID_SIDE && y >= 0 && y < GRID_SIDE;
    endfunction

    // Wall on this cell plus the mirrored wall on the neighbour, if any
    function void mark_wall(int dir);
      int nx, ny;
      dir = dir & 3;
      walls[px + py * GRID_SIDE][dir] = 1'b1;
      if (step_to(dir, nx, ny))
        walls[nx + ny * GRID_SIDE][(dir + 2) & 3] = 1'b1;
    endfunction

    // Relocate; heading follows the move only when the new cell is adjacent
    function void go_to(int x, int y);
      if (x == px && y == py + 1)      face = mde_pkg::DIR_N;
      else if (y == py && x == px + 1) face = mde_pkg::DIR_E;
      else if (x == px && y + 1 == py) face = mde_pkg::DIR_S;
      else if (y == py && x + 1 == px) face = mde_pkg::DIR_W;
      px = x;
      py = y;
    endfunction

    // Work out the move caused by an accepted transaction
    function void note_request(mde_pkg::in_item_t req);
      mde_pkg::out_item_t res;
      int        here, nx, ny, top;
      bit        found;
      bit        acted;
      res.status = mde_pkg::ST_IGNORED;
      acted      = 1'b0;
      nx         = px;
      ny         = py;
      if (req.req_type == mde_pkg::REQ_START) begin
        if (mode == mde_pkg::MODE_IDLE) begin
          trail[0]  = px + py * GRID_SIDE;
          trail_len = 1;
          seen[px + py * GRID_SIDE] = 1'b1;
          mode  = mde_pkg::MODE_EXPLORE;
          acted = 1'b1;
        end
      end else if (mode == mde_pkg::MODE_EXPLORE) begin
        acted = 1'b1;
        if (req.front_level > threshold) mark_wall(face);
        if (req.left_level > threshold)  mark_wall(face + 3);
        if (req.right_level > threshold) mark_wall(face + 1);
        here = px + py * GRID_SIDE;
        seen[here] = 1'b1;
        // goal cells past the grid edge can never equal the position
        if ((px == goal_x || px == goal_x + 1) && (py == goal_y || py == goal_y + 1)) begin
          mode       = mde_pkg::MODE_GOAL;
          res.status = mde_pkg::ST_GOAL;
        end else begin
          found = 1'b0;
          for (int d = 0; d < 4 && !found; d++)
            if (!walls[here][d] && step_to(d, nx, ny) && !seen[nx + ny * GRID_SIDE])
              found = 1'b1;
          if (found) begin
            // a full trail drops the push but the robot still moves
            if (trail_len < CELLS) begin
              trail[trail_len] = nx + ny * GRID_SIDE;
              trail_len++;
            end
            go_to(nx, ny);
            res.status = mde_pkg::ST_ADVANCE;
          end else if (trail_len <= 1) begin
            mode       = mde_pkg::MODE_DONE;
            res.status = mde_pkg::ST_EXHAUSTED;
          end else begin
            trail_len--;
            top = trail[trail_len - 1];
            go_to(top % GRID_SIDE, top / GRID_SIDE);
            res.status = mde_pkg::ST_BACKTRACK;
          end
        end
      end
      res.target_x = 4'(px);
      res.target_y = 4'(py);
      res.heading  = face;
      if (acted) live_results++;
      moves_due = {moves_due, res};
    endfunction

    function void compare_field(string name, logic [3:0] want, logic [3:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      end
    endfunction

    function void check_move(mde_pkg::out_item_t got);
      mde_pkg::out_item_t want;
      if (moves_due.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected, status %0d x %0d y %0d heading %0d",
                 $time, got.status, got.target_x, got.target_y, got.heading);
        return;
      end
      want = moves_due.pop_front();
      compare_field("status", want.status, got.status);
      compare_field("target_x", want.target_x, got.target_x);
      compare_field("target_y", want.target_y, got.target_y);
      compare_field("heading", want.heading, got.heading);
    endfunction
  endclass

  logic                       clk       = 1'b0;
  logic                       rst_n     = 1'b0;
  logic                       in_valid  = 1'b0;
  logic                       in_ready;
  mde_pkg::in_item_t          in_data   = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  mde_pkg::out_item_t         out_data;
  logic                       cfg_we    = 1'b0;
  logic [mde_pkg::CFG_AW-1:0] cfg_addr  = mde_pkg::CFG_WALL_THRESHOLD;
  logic [mde_pkg::CFG_DW-1:0] cfg_wdata = '0;

  maze_scoreboard sb;
  int n_taken   = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  maze_dfs_explorer #(.GRID_SIDE(GRID_SIDE)) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Window of transactions with no idling on either side
  function automatic bit calm();
    return n_taken >= 150 && n_taken < 260;
  endfunction

  function automatic mde_pkg::in_item_t make_req(logic [0:0] kind, logic [11:0] lvl_l,
                                                 logic [11:0] lvl_f, logic [11:0] lvl_r);
    mde_pkg::in_item_t req;
    req.req_type    = kind;
    req.left_level  = lvl_l;
    req.front_level = lvl_f;
    req.right_level = lvl_r;
    return req;
  endfunction

  // Sensor level: a wall with roughly wall_pct percent odds, sometimes fully random
  function automatic logic [11:0] sensor_level(logic [11:0] thr, int wall_pct);
    if ($urandom_range(99) < 10) return 12'($urandom_range(4095));
    if ($urandom_range(99) < wall_pct && thr != 12'hFFF)
      return 12'($urandom_range(4095, int'(thr) + 1));
    return 12'($urandom_range(int'(thr), 0));
  endfunction

  // Smallest Manhattan distance from the robot to an in-grid cell of a goal block
  function automatic int goal_gap(int gx, int gy);
    int gap, cx, cy, d;
    gap = 4 * GRID_SIDE;
    for (int dx = 0; dx < 2; dx++)
      for (int dy = 0; dy < 2; dy++) begin
        cx = gx + dx;
        cy = gy + dy;
        if (cx < GRID_SIDE && cy < GRID_SIDE) begin
          d = ((cx > sb.px) ? cx - sb.px : sb.px - cx) + ((cy > sb.py) ? cy - sb.py : sb.py - cy);
          if (d < gap) gap = d;
        end
      end
    return gap;
  endfunction

  // Goal block the robot cannot reach within n steps, n at most want; every move
  // is to an adjacent cell, so the goal stays out of reach for the whole phase
  task automatic plan_goal(input int want, output logic [3:0] gx, output logic [3:0] gy,
                           output int n);
    int far;
    far = 0;
    for (int x = 0; x < GRID_SIDE; x++)
      for (int y = 0; y < GRID_SIDE; y++)
        if (goal_gap(x, y) > far) far = goal_gap(x, y);
    n = (want < far) ? want : far;
    do begin
      gx = 4'($urandom_range(15));
      gy = 4'($urandom_range(15));
    end while (goal_gap(gx, gy) < n);
  endtask

  // All three registers, back to back; upper data bits of the goal writes are junk
  task automatic program_regs(input logic [11:0] thr, input logic [3:0] gx,
                              input logic [3:0] gy);
    cfg_we    <= 1'b1;
    cfg_addr  <= mde_pkg::CFG_WALL_THRESHOLD;
    cfg_wdata <= thr;
    @(posedge clk);
    cfg_addr  <= mde_pkg::CFG_GOAL_X;
    cfg_wdata <= {8'($urandom), gx};
    @(posedge clk);
    cfg_addr  <= mde_pkg::CFG_GOAL_Y;
    cfg_wdata <= {8'($urandom), gy};
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.set_regs(thr, gx, gy);
  endtask

  // One transaction on the request side, with random idle cycles ahead of it
  task automatic offer(input mde_pkg::in_item_t req);
    while (!calm() && $urandom_range(99) < 29) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (!in_ready);
  endtask

  // Stop sending until every owed move has come back
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Transaction monitor: prediction on acceptance, check on delivery
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      sb.note_request(in_data);
      n_taken <= n_taken + 1;
    end
    if (rst_n && out_valid && out_ready) sb.check_move(out_data);
  end

  // Result side: random back-pressure, one long hold-off to fill the block
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (!hold_done && n_taken >= 40) begin
      hold_done <= 1'b1;
      hold_left <= 120;
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm() || ($urandom_range(99) >= 29);
    end
  end

  // Watchdog
  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Regression FAIL");
    $finish;
  end

  initial begin : stimulus
    logic [11:0] thr;
    logic [3:0]  gx, gy;
    int          n, wall_pct;
    bit          end_on_goal;
    sb = new();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: goal in the far corner, partly past the grid edge
    program_regs(12'd2000, 4'd15, 4'd15);
    offer(make_req(mde_pkg::REQ_STEP, 12'hFFF, 12'hFFF, 12'hFFF));   // step while idle
    offer(make_req(mde_pkg::REQ_START, 12'hFFF, 12'd0, 12'hFFF));
    offer(make_req(mde_pkg::REQ_START, 12'd0, 12'd0, 12'd0));        // start while exploring
    offer(make_req(mde_pkg::REQ_STEP, 12'd0, 12'd0, 12'd0));
    offer(make_req(mde_pkg::REQ_STEP, 12'd2000, 12'd2000, 12'd2000)); // level equal to threshold
    offer(make_req(mde_pkg::REQ_STEP, 12'd2001, 12'd2001, 12'd2001)); // just above it
    offer(make_req(mde_pkg::REQ_STEP, 12'd0, 12'hFFF, 12'd0));
    offer(make_req(mde_pkg::REQ_STEP, 12'hFFF, 12'd0, 12'd0));
    offer(make_req(mde_pkg::REQ_STEP, 12'd0, 12'd0, 12'hFFF));
    offer(make_req(mde_pkg::REQ_STEP, 12'hFFF, 12'hFFF, 12'hFFF));
    settle();
    // top threshold: nothing counts as a wall
    program_regs(12'hFFF, 4'd15, 4'd15);
    repeat (4) offer(make_req(mde_pkg::REQ_STEP, 12'hFFF, 12'hFFF, 12'hFFF));
    settle();
    // zero threshold: any non-zero level is a wall
    program_regs(12'd0, 4'd15, 4'd15);
    offer(make_req(mde_pkg::REQ_STEP, 12'd0, 12'd0, 12'd0));
    offer(make_req(mde_pkg::REQ_STEP, 12'd1, 12'd0, 12'd0));
    offer(make_req(mde_pkg::REQ_STEP, 12'd0, 12'd1, 12'd0));
    offer(make_req(mde_pkg::REQ_STEP, 12'd0, 12'd0, 12'd1));
    offer(make_req(mde_pkg::REQ_STEP, 12'd0, 12'd0, 12'd0));
    settle();

    // Random exploration in phases, goal kept out of reach
    end_on_goal = 1'($urandom_range(1));
    while (sb.mode == mde_pkg::MODE_EXPLORE && sb.live_results < MOVE_TARGET) begin
      case ($urandom_range(9))
        0:       thr = 12'd0;
        1:       thr = 12'hFFF;
        default: thr = 12'($urandom_range(4095));
      endcase
      plan_goal($urandom_range(40, 8), gx, gy, n);
      program_regs(thr, gx, gy);
      wall_pct = $urandom_range(25, 5);
      repeat (n) begin
        if ($urandom_range(99) < 4)
          offer(make_req(mde_pkg::REQ_START, 12'($urandom), 12'($urandom), 12'($urandom)));
        else
          offer(make_req(mde_pkg::REQ_STEP, sensor_level(thr, wall_pct),
                         sensor_level(thr, wall_pct), sensor_level(thr, wall_pct)));
      end
      settle();
    end

    // Finish the exploration: goal on the current cell, or walls everywhere
    if (sb.mode == mde_pkg::MODE_EXPLORE) begin
      if (end_on_goal) begin
        program_regs(12'($urandom_range(4095)), 4'(sb.px), 4'(sb.py));
        offer(make_req(mde_pkg::REQ_STEP, 12'($urandom), 12'($urandom), 12'($urandom)));
        settle();
      end else begin
        while (sb.mode == mde_pkg::MODE_EXPLORE) begin
          plan_goal(40, gx, gy, n);
          program_regs(12'd0, gx, gy);
          repeat (n) offer(make_req(mde_pkg::REQ_STEP, 12'hFFF, 12'hFFF, 12'hFFF));
          settle();
        end
      end
    end

    // After the end every request is ignored
    offer(make_req(mde_pkg::REQ_START, 12'($urandom), 12'($urandom), 12'($urandom)));
    offer(make_req(mde_pkg::REQ_STEP, 12'hFFF, 12'd0, 12'hFFF));
    offer(make_req(mde_pkg::REQ_STEP, 12'($urandom), 12'($urandom), 12'($urandom)));
    settle();
    repeat (20) @(posedge clk);

    if (sb.errors == 0 && sb.pending() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
